[src/ets_pkg.sv]
// Shared types and character constants for the expression token scanner.
`default_nettype none

package ets_pkg;

    typedef enum logic [3:0] {
        K_NUMBER    = 4'd0,
        K_NAME_CHAR = 4'd1,
        K_NAME_END  = 4'd2,
        K_STR_CHAR  = 4'd3,
        K_STR_END   = 4'd4,
        K_PLUS      = 4'd5,
        K_MINUS     = 4'd6,
        K_STAR      = 4'd7,
        K_SLASH     = 4'd8,
        K_LPAREN    = 4'd9,
        K_RPAREN    = 4'd10,
        K_BAD_CHAR  = 4'd11,
        K_UNTERM    = 4'd12
    } t_kind;

    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_NEWLINE = 8'h0A;
    localparam logic [7:0] C_DOT     = 8'h2E;
    localparam logic [7:0] C_QUOTE   = 8'h22;
    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_MINUS   = 8'h2D;
    localparam logic [7:0] C_STAR    = 8'h2A;
    localparam logic [7:0] C_SLASH   = 8'h2F;
    localparam logic [7:0] C_LPAREN  = 8'h28;
    localparam logic [7:0] C_RPAREN  = 8'h29;

    localparam int unsigned FIFO_DEPTH = 4;

    // Results pushed into the queue in one cycle (0, 1 or 2).
    typedef struct packed {
        logic [1:0] cnt;
    } t_push;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

`default_nettype wire

[src/ets_result_fifo.sv]
// Result queue between the scanner and the output channel.
`default_nettype none

module ets_result_fifo
    import ets_pkg::*;
#(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_push            i_push,
    input  wire logic [WIDTH-1:0] i_data0,
    input  wire logic [WIDTH-1:0] i_data1,
    output logic                  o_room,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_stall
);

    localparam int unsigned PW = $clog2(FIFO_DEPTH);

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [PW:0]      r_count, n_count;
    logic             pop;
    logic [PW-1:0]    wr1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= (PW+1)'(FIFO_DEPTH - 2));
    assign wr1     = r_wr + 1'b1;

    always_comb begin
        n_wr    = r_wr + PW'(i_push.cnt);
        n_rd    = pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (PW+1)'(i_push.cnt) - (PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr1] <= i_data1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(FIFO_DEPTH))
        else $error("result queue over capacity");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("push without room");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not drain an entry");

endmodule

`default_nettype wire

[src/ets_scan.sv]
// Input register and per-byte scanner state update.
`default_nettype none

module ets_scan
    import ets_pkg::*;
#(
    parameter int unsigned MANTISSA_BITS = 48,
    parameter int unsigned POSITION_BITS = 16,
    parameter int unsigned WIDTH         = 4 + 8 + MANTISSA_BITS + 4 + 1
                                           + 2 * POSITION_BITS + 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_text_byte,
    input  wire logic             i_end_of_text,
    output logic                  o_stall,
    input  wire logic             i_room,
    output t_push                 o_push,
    output logic [WIDTH-1:0]      o_data0,
    output logic [WIDTH-1:0]      o_data1
);

    localparam int unsigned M = MANTISSA_BITS;
    localparam int unsigned P = POSITION_BITS;
    localparam logic [M-1:0] MANT_MAX = {M{1'b1}};
    localparam logic [P-1:0] POS_MAX  = {P{1'b1}};

    typedef enum logic [5:0] {
        M_IDLE   = 6'b000001,
        M_INT    = 6'b000010,
        M_FRAC   = 6'b000100,
        M_NAME   = 6'b001000,
        M_STRING = 6'b010000,
        M_HALT   = 6'b100000
    } t_mode;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   ch;
        logic [M-1:0] mant;
        logic [3:0]   frac;
        logic         ovf;
    } t_tok;

    function automatic t_tok mk(input t_kind k, input logic [7:0] c,
                                input logic [M-1:0] mt, input logic [3:0] fr,
                                input logic ov);
        t_tok t;
        t.kind = k;
        t.ch   = c;
        t.mant = mt;
        t.frac = fr;
        t.ovf  = ov;
        return t;
    endfunction

    logic         r_in_valid;
    logic [7:0]   r_byte;
    logic         r_end;
    t_mode        r_mode, n_mode;
    logic [M-1:0] r_value, n_value;
    logic [3:0]   r_frac, n_frac;
    logic         r_ovf, n_ovf;
    logic [P-1:0] r_line, n_line;
    logic [P-1:0] r_col, n_col;

    logic         fire;
    logic         accept;
    logic [M+3:0] wide;
    logic         fits;
    logic         dig;
    logic         alpha;
    logic [P-1:0] col_inc;
    t_tok         res [2];
    logic [1:0]   cnt;
    logic         fresh;

    assign fire    = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign accept  = i_valid && !o_stall;
    assign dig     = is_digit(r_byte);
    assign alpha   = is_alpha(r_byte);
    assign col_inc = (r_col != POS_MAX) ? r_col + 1'b1 : r_col;

    // value * 10 + digit, one extra nibble to see the carry out
    assign wide = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1)
                  + (M+4)'(r_byte[3:0]);
    assign fits = (wide[M+3:M] == 4'd0);

    always_comb begin
        n_mode  = r_mode;
        n_value = r_value;
        n_frac  = r_frac;
        n_ovf   = r_ovf;
        n_line  = r_line;
        n_col   = r_col;
        res[0]  = '0;
        res[1]  = '0;
        cnt     = 2'd0;
        fresh   = 1'b0;

        if (fire && r_mode != M_HALT) begin
            n_col = col_inc;
            unique case (r_mode)
                M_INT: begin
                    if (dig) begin
                        if (fits) begin
                            n_value = wide[M-1:0];
                        end else begin
                            n_value = MANT_MAX;
                            n_ovf   = 1'b1;
                        end
                    end else if (r_byte == C_DOT) begin
                        n_mode = M_FRAC;
                    end else begin
                        res[cnt[0]] = mk(K_NUMBER, 8'd0, r_value, r_frac, r_ovf);
                        cnt     = cnt + 2'd1;
                        n_value = '0;
                        n_frac  = '0;
                        n_ovf   = 1'b0;
                        fresh   = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (dig) begin
                        if (!fits || r_frac == 4'd15) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_value = wide[M-1:0];
                            n_frac  = r_frac + 4'd1;
                        end
                    end else begin
                        res[cnt[0]] = mk(K_NUMBER, 8'd0, r_value, r_frac, r_ovf);
                        cnt     = cnt + 2'd1;
                        n_value = '0;
                        n_frac  = '0;
                        n_ovf   = 1'b0;
                        fresh   = 1'b1;
                    end
                end
                M_NAME: begin
                    if (dig || alpha) begin
                        if (r_end) begin
                            res[cnt[0]] = mk(K_NAME_END, r_byte, '0, 4'd0, 1'b0);
                            n_mode = M_IDLE;
                        end else begin
                            res[cnt[0]] = mk(K_NAME_CHAR, r_byte, '0, 4'd0, 1'b0);
                        end
                        cnt = cnt + 2'd1;
                    end else begin
                        res[cnt[0]] = mk(K_NAME_END, 8'd0, '0, 4'd0, 1'b0);
                        cnt   = cnt + 2'd1;
                        fresh = 1'b1;
                    end
                end
                M_STRING: begin
                    if (r_byte == C_QUOTE) begin
                        res[cnt[0]] = mk(K_STR_END, 8'd0, '0, 4'd0, 1'b0);
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt[0]] = mk(K_STR_CHAR, r_byte, '0, 4'd0, 1'b0);
                    end
                    cnt = cnt + 2'd1;
                end
                default: begin
                    fresh = 1'b1;
                end
            endcase

            // rescan the terminating byte as the start of a new token
            if (fresh) begin
                n_mode = M_IDLE;
                if (r_byte == C_SPACE || r_byte == C_NEWLINE) begin
                    n_mode = M_IDLE;
                end else if (dig) begin
                    n_value = M'(r_byte[3:0]);
                    n_frac  = '0;
                    n_ovf   = 1'b0;
                    n_mode  = M_INT;
                end else if (alpha) begin
                    if (r_end) begin
                        res[cnt[0]] = mk(K_NAME_END, r_byte, '0, 4'd0, 1'b0);
                    end else begin
                        res[cnt[0]] = mk(K_NAME_CHAR, r_byte, '0, 4'd0, 1'b0);
                        n_mode = M_NAME;
                    end
                    cnt = cnt + 2'd1;
                end else if (r_byte == C_QUOTE) begin
                    n_mode = M_STRING;
                end else begin
                    case (r_byte)
                        C_PLUS:   res[cnt[0]] = mk(K_PLUS, 8'd0, '0, 4'd0, 1'b0);
                        C_MINUS:  res[cnt[0]] = mk(K_MINUS, 8'd0, '0, 4'd0, 1'b0);
                        C_STAR:   res[cnt[0]] = mk(K_STAR, 8'd0, '0, 4'd0, 1'b0);
                        C_SLASH:  res[cnt[0]] = mk(K_SLASH, 8'd0, '0, 4'd0, 1'b0);
                        C_LPAREN: res[cnt[0]] = mk(K_LPAREN, 8'd0, '0, 4'd0, 1'b0);
                        C_RPAREN: res[cnt[0]] = mk(K_RPAREN, 8'd0, '0, 4'd0, 1'b0);
                        default: begin
                            res[cnt[0]] = mk(K_BAD_CHAR, r_byte, '0, 4'd0, 1'b0);
                            n_mode = M_HALT;
                        end
                    endcase
                    cnt = cnt + 2'd1;
                end
            end

            if (r_byte == C_NEWLINE) begin
                if (r_line != POS_MAX) begin
                    n_line = r_line + 1'b1;
                end
                n_col = '0;
            end

            // flush pending token at end of text, then restart at line 1, column 0 unless halted
            if (r_end && n_mode != M_HALT) begin
                if (n_mode == M_INT || n_mode == M_FRAC) begin
                    res[cnt[0]] = mk(K_NUMBER, 8'd0, n_value, n_frac, n_ovf);
                    cnt     = cnt + 2'd1;
                    n_value = '0;
                    n_frac  = '0;
                    n_ovf   = 1'b0;
                    n_mode  = M_IDLE;
                end else if (n_mode == M_STRING) begin
                    res[cnt[0]] = mk(K_UNTERM, 8'd0, '0, 4'd0, 1'b0);
                    cnt    = cnt + 2'd1;
                    n_mode = M_HALT;
                end
                if (n_mode != M_HALT) begin
                    n_mode = M_IDLE;
                    n_line = P'(1);
                    n_col  = '0;
                end
            end
        end
    end

    assign o_push.cnt = cnt;
    assign o_data0    = {res[0], r_line, col_inc, (cnt == 2'd1)};
    assign o_data1    = {res[1], r_line, col_inc, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_value    <= '0;
            r_frac     <= '0;
            r_ovf      <= 1'b0;
            r_line     <= P'(1);
            r_col      <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_mode  <= n_mode;
            r_value <= n_value;
            r_frac  <= n_frac;
            r_ovf   <= n_ovf;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_text_byte;
            r_end  <= i_end_of_text;
        end
    end

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |=> (r_mode == M_HALT))
        else $error("scanner left halt without reset");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_end && r_mode != M_HALT) |=>
            ((r_mode == M_IDLE && r_line == P'(1) && r_col == '0) || r_mode == M_HALT))
        else $error("end of text did not restart position");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter hit zero");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |-> (cnt == 2'd0))
        else $error("result produced while halted");

endmodule

`default_nettype wire

[src/expression_token_scanner_unit.sv]
// Top level of the expression token scanner.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_text_byte, i_end_of_text
//  output   out        o_valid / i_stall   o_kind .. o_run_last
//
// One byte is scanned per cycle while the queue has room: a request lands in the
// input register, and once the queue has room the scanner updates its state from
// that register and pushes 0 to 2 results into a four-entry result queue. The
// input stalls only while the queue cannot take two more results; bytes that
// yield two results drain at one result per cycle while i_stall is low.
// Reset is synchronous: scanner idle, line 1, column 0, queue empty.
`default_nettype none

module expression_token_scanner_unit
    import ets_pkg::*;
#(
    parameter int unsigned MANTISSA_BITS = 48,
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [7:0]               i_text_byte,
    input  wire logic                     i_end_of_text,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [3:0]                    o_kind,
    output logic [7:0]                    o_char_out,
    output logic [MANTISSA_BITS-1:0]      o_mantissa,
    output logic [3:0]                    o_fraction_digits,
    output logic                          o_overflowed,
    output logic [POSITION_BITS-1:0]      o_line,
    output logic [POSITION_BITS-1:0]      o_column,
    output logic                          o_run_last
);

    localparam int unsigned M = MANTISSA_BITS;
    localparam int unsigned P = POSITION_BITS;
    localparam int unsigned WIDTH = 4 + 8 + M + 4 + 1 + 2 * P + 1;

    t_push            push;
    logic [WIDTH-1:0] data0;
    logic [WIDTH-1:0] data1;
    logic [WIDTH-1:0] head;
    logic             room;

    ets_scan #(
        .MANTISSA_BITS (M),
        .POSITION_BITS (P),
        .WIDTH         (WIDTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_stall       (o_stall),
        .i_room        (room),
        .o_push        (push),
        .o_data0       (data0),
        .o_data1       (data1)
    );

    ets_result_fifo #(
        .WIDTH (WIDTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (data0),
        .i_data1 (data1),
        .o_room  (room),
        .o_valid (o_valid),
        .o_data  (head),
        .i_stall (i_stall)
    );

    assign {o_kind, o_char_out, o_mantissa, o_fraction_digits, o_overflowed,
            o_line, o_column, o_run_last} = head;

endmodule

`default_nettype wire
